@@ sv/mau_pkg.sv @@
// ---------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit.
// ---------------------------------------------------------------------------
package mau_pkg;

    // operation selector codes
    typedef enum logic [3:0] {
        FN_REDUCE = 4'd0,
        FN_ADD    = 4'd1,
        FN_SUB    = 4'd2,
        FN_MUL    = 4'd3,
        FN_POW    = 4'd4,
        FN_INV    = 4'd5,
        FN_DIV    = 4'd6,
        FN_INC    = 4'd7,
        FN_DEC    = 4'd8,
        FN_NEG    = 4'd9,
        FN_EQ     = 4'd10,
        FN_NEQ    = 4'd11
    } t_func;

    localparam int FUNC_W = 4;
    localparam int RAW_W  = 64;
    localparam int CNT_W  = 7;
    localparam logic [30:0] MOD_RESET = 31'd998244353;

endpackage

@@ sv/modular_arithmetic_unit.sv @@
// ---------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular arithmetic over a programmable modulus with Fermat inverse.
// ---------------------------------------------------------------------------
// Usage: a request arrives on the s_axis channel (tuser = func, tdata =
// operand_a, operand_b, exponent, raw_value from bit 0 up) and one result
// leaves on the m_axis channel. The modulus is written through i_cfg_we /
// i_cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. All reductions and products, also the
// 64-bit signed reduce, go through one bit-serial multiply/reduce unit.
// Operands are first reduced, a then b. Add, sub, inc, dec, negate and
// compares then finish in S_EXEC; mul takes one more product; pow takes up
// to 2*EXP_WIDTH products; inverse and divide take a power with exponent
// modulus-2 (plus one product for divide). A modulus below 2 answers in
// the cycle after the request is accepted. One request is handled at a
// time: s_axis tready is high only when idle. The result is held in an
// output register until the receiver takes it; a stall on m_axis simply
// holds the block. Reset restores the modulus to 998244353 and returns to
// idle; there is no clearing pass.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int VALUE_WIDTH = 31,
    parameter int EXP_WIDTH   = 63
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [VALUE_WIDTH-1:0] i_cfg_wdata,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // operand_a, operand_b, exponent, raw_value, zero pad
    input  logic [((2*VALUE_WIDTH+EXP_WIDTH+RAW_W+7)/8)*8-1:0] i_s_axis_tdata,
    // func
    input  logic [FUNC_W-1:0]     i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // result, zero pad
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int VW = VALUE_WIDTH;
    localparam int XW = (EXP_WIDTH > VALUE_WIDTH) ? EXP_WIDTH : VALUE_WIDTH;
    localparam int OW = ((VALUE_WIDTH+7)/8)*8;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RA    = 9'b000000010,
        S_RB    = 9'b000000100,
        S_EXEC  = 9'b000001000,
        S_RAW   = 9'b000010000,
        S_PLOOP = 9'b000100000,
        S_PMUL  = 9'b001000000,
        S_PSQ   = 9'b010000000,
        S_FMUL  = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic [VW-1:0]        r_mod;
    logic [FUNC_W-1:0]    r_func;
    logic [VW-1:0]        r_a, r_b, r_ra, r_rb, r_acc, r_base, r_res;
    logic [VW-1:0]        n_ra, n_rb, n_acc, n_base, n_res;
    logic [XW-1:0]        r_exp, n_exp;
    logic [RAW_W-1:0]     r_raw;
    logic                 r_div, n_div;

    logic                 u_start, u_done;
    logic [VW-1:0]        u_x, u_res;
    logic [RAW_W-1:0]     u_y;
    logic [CNT_W-1:0]     u_n;

    logic                 in_fire, raw_neg;
    logic [RAW_W-1:0]     raw_mag;
    logic [VW:0]          add_s, sub_s, inc_s;
    logic [VW-1:0]        alu;

    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OW'(r_res);

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= VW'(MOD_RESET);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata;
        end
    end

    // shared multiply/reduce unit
    mau_mulred #(.VALUE_WIDTH(VW)) u_mulred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mod   (r_mod),
        .i_start (u_start),
        .i_x     (u_x),
        .i_y     (u_y),
        .i_n     (u_n),
        .o_done  (u_done),
        .o_res   (u_res)
    );

    // combinational ops on reduced operands
    always_comb begin
        add_s = {1'b0, r_ra} + {1'b0, r_rb};
        sub_s = {1'b0, r_ra} + {1'b0, r_mod} - {1'b0, r_rb};
        inc_s = {1'b0, r_ra} + (VW+1)'(1);
        unique case (r_func)
            FN_ADD:  alu = (add_s >= {1'b0, r_mod}) ? VW'(add_s - {1'b0, r_mod})
                                                    : VW'(add_s);
            FN_SUB:  alu = (r_ra >= r_rb) ? r_ra - r_rb : VW'(sub_s);
            FN_INC:  alu = (inc_s >= {1'b0, r_mod}) ? '0 : VW'(inc_s);
            FN_DEC:  alu = (r_ra == '0) ? r_mod - VW'(1) : r_ra - VW'(1);
            FN_NEG:  alu = (r_ra == '0) ? '0 : r_mod - r_ra;
            FN_EQ:   alu = VW'(r_ra == r_rb);
            FN_NEQ:  alu = VW'(r_ra != r_rb);
            default: alu = '0;
        endcase
    end

    assign raw_neg = r_raw[RAW_W-1];
    assign raw_mag = raw_neg ? (~r_raw + RAW_W'(1)) : r_raw;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_ra   = r_ra;
        n_rb   = r_rb;
        n_acc  = r_acc;
        n_base = r_base;
        n_exp  = r_exp;
        n_res  = r_res;
        n_div  = r_div;
        u_start = 1'b0;
        u_x     = VW'(1);
        u_y     = '0;
        u_n     = CNT_W'(VW);
        unique case (r_state)
            S_IDLE: begin
                if (r_out_valid && i_m_axis_tready) begin
                    n_out_valid = 1'b0;
                end
                if (in_fire) begin
                    if (r_mod < VW'(2)) begin
                        n_res       = VW'(i_s_axis_tuser == FN_EQ);
                        n_out_valid = 1'b1;
                    end else begin
                        u_start = 1'b1;
                        u_y     = {i_s_axis_tdata[VW-1:0], {(RAW_W-VW){1'b0}}};
                        n_state = S_RA;
                    end
                end
            end
            S_RA: begin
                if (u_done) begin
                    n_ra    = u_res;
                    u_start = 1'b1;
                    u_y     = {r_b, {(RAW_W-VW){1'b0}}};
                    n_state = S_RB;
                end
            end
            S_RB: begin
                if (u_done) begin
                    n_rb    = u_res;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_acc  = VW'(1);
                n_div  = 1'b0;
                n_state = S_IDLE;
                n_out_valid = 1'b1;
                n_res  = alu;
                priority if (r_func == FN_REDUCE) begin
                    u_start = 1'b1;
                    u_y     = raw_mag;
                    u_n     = CNT_W'(RAW_W);
                    n_out_valid = 1'b0;
                    n_state = S_RAW;
                end else if (r_func == FN_MUL) begin
                    u_start = 1'b1;
                    u_x     = r_ra;
                    u_y     = {r_rb, {(RAW_W-VW){1'b0}}};
                    n_out_valid = 1'b0;
                    n_state = S_FMUL;
                end else if (r_func == FN_POW) begin
                    n_base  = r_ra;
                    n_out_valid = 1'b0;
                    n_state = S_PLOOP;
                end else if (r_func == FN_INV && r_ra != '0) begin
                    n_base  = r_ra;
                    n_exp   = XW'(r_mod) - XW'(2);
                    n_out_valid = 1'b0;
                    n_state = S_PLOOP;
                end else if (r_func == FN_DIV && r_rb != '0) begin
                    n_base  = r_rb;
                    n_exp   = XW'(r_mod) - XW'(2);
                    n_div   = 1'b1;
                    n_out_valid = 1'b0;
                    n_state = S_PLOOP;
                end else begin
                    n_res = alu;
                end
            end
            S_RAW: begin
                if (u_done) begin
                    n_res = (raw_neg && u_res != '0) ? r_mod - u_res : u_res;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PLOOP: begin
                u_start = 1'b1;
                if (r_exp == '0) begin
                    if (r_div) begin
                        u_x     = r_ra;
                        u_y     = {r_acc, {(RAW_W-VW){1'b0}}};
                        n_state = S_FMUL;
                    end else begin
                        u_start = 1'b0;
                        n_res   = r_acc;
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_exp[0]) begin
                    u_x     = r_acc;
                    u_y     = {r_base, {(RAW_W-VW){1'b0}}};
                    n_state = S_PMUL;
                end else begin
                    u_x     = r_base;
                    u_y     = {r_base, {(RAW_W-VW){1'b0}}};
                    n_state = S_PSQ;
                end
            end
            S_PMUL: begin
                if (u_done) begin
                    n_acc   = u_res;
                    u_start = 1'b1;
                    u_x     = r_base;
                    u_y     = {r_base, {(RAW_W-VW){1'b0}}};
                    n_state = S_PSQ;
                end
            end
            S_PSQ: begin
                if (u_done) begin
                    n_base  = u_res;
                    n_exp   = r_exp >> 1;
                    n_state = S_PLOOP;
                end
            end
            S_FMUL: begin
                if (u_done) begin
                    n_res   = u_res;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a    <= i_s_axis_tdata[VW-1:0];
            r_b    <= i_s_axis_tdata[2*VW-1:VW];
            r_exp  <= XW'(i_s_axis_tdata[2*VW+EXP_WIDTH-1:2*VW]);
            r_raw  <= i_s_axis_tdata[2*VW+EXP_WIDTH+RAW_W-1:2*VW+EXP_WIDTH];
            r_func <= i_s_axis_tuser;
        end else begin
            r_exp  <= n_exp;
        end
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_acc  <= n_acc;
        r_base <= n_base;
        r_res  <= n_res;
        r_div  <= n_div;
    end

endmodule

@@ sv/mau_mulred.sv @@
// ---------------------------------------------------------------------------
// mau_mulred
// Bit-serial modular multiply and reduce: r = 2r + bit*x mod m per cycle,
// walking the y word from its top bit through its first n bits.
// ---------------------------------------------------------------------------
module mau_mulred
    import mau_pkg::*;
#(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_WIDTH-1:0] i_mod,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_x,
    input  logic [RAW_W-1:0]       i_y,
    input  logic [CNT_W-1:0]       i_n,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_res
);

    logic [VALUE_WIDTH-1:0] r_r, n_r;
    logic [VALUE_WIDTH-1:0] r_x;
    logic [RAW_W-1:0]       r_y;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy, r_done;
    logic [VALUE_WIDTH:0]   dbl, dbl_red, sum;

    // one doubling, conditional add, two compare-subtracts
    always_comb begin
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= {1'b0, i_mod}) ? dbl - {1'b0, i_mod} : dbl;
        sum     = dbl_red + (r_y[RAW_W-1] ? {1'b0, r_x} : '0);
        n_r     = (sum >= {1'b0, i_mod}) ? VALUE_WIDTH'(sum - {1'b0, i_mod})
                                         : VALUE_WIDTH'(sum);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r   <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_cnt <= i_n;
        end else if (r_busy) begin
            r_r   <= n_r;
            r_y   <= {r_y[RAW_W-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule

@@ tb/modular_arithmetic_unit_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// modular_arithmetic_unit_tb
// Self-checking bench for the modular arithmetic unit. Requests are driven on
// s_axis with random gaps, results are taken on m_axis with random stalls and
// compared against an in-bench residue predictor, over several moduli.
// ---------------------------------------------------------------------------
module modular_arithmetic_unit_tb
    import mau_pkg::*;
();

    localparam int VW       = 31;
    localparam int EW       = 63;
    localparam int DATA_W   = ((2*VW+EW+RAW_W+7)/8)*8;
    localparam int RES_W    = ((VW+7)/8)*8;
    localparam int WDOG_MAX = 40000;
    localparam logic [VW-1:0] MOD_MAX = 31'h7FFFFFFF;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [VW-1:0]     i_cfg_wdata = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    // operand_a, operand_b, exponent, raw_value, zero pad
    logic [DATA_W-1:0] i_s_axis_tdata = '0;
    // func
    logic [FUNC_W-1:0] i_s_axis_tuser = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    // result, zero pad
    logic [RES_W-1:0]  o_m_axis_tdata;

    logic [VW-1:0]     cur_modulus;
    logic [VW-1:0]     result_q[$];
    int                err_cnt = 0;
    int                idle_cycles = 0;
    int                rx_stall = 0;
    int                rx_cnt = 0;
    int                rx_seen = 0;
    int                hold_len = 0;
    int                hold_seq = 0;
    int                hold_seen = 0;
    bit                quiet = 1'b0;

    modular_arithmetic_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // residue arithmetic
    function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        return (x * y) % m;
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] base, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        while (e != 64'd0) begin
            if (e[0]) acc = mod_mul(acc, base, m);
            base = mod_mul(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_inv(logic [63:0] x, logic [63:0] m);
        if (x == 64'd0) return 64'd0;
        return mod_pow(x, m - 64'd2, m);
    endfunction

    function automatic logic [VW-1:0] residue_of(logic [3:0] fn, logic [VW-1:0] opa,
                                                 logic [VW-1:0] opb, logic [EW-1:0] e,
                                                 logic [63:0] raw);
        logic [63:0] m, a, b, r, mag;
        m = {33'd0, cur_modulus};
        if (m < 64'd2) return VW'(fn == FN_EQ);
        a = {33'd0, opa} % m;
        b = {33'd0, opb} % m;
        r = '0;
        case (fn)
            FN_REDUCE: begin
                if (!raw[63]) r = raw % m;
                else begin
                    mag = ~raw + 64'd1;
                    r = mag % m;
                    r = (r == 64'd0) ? 64'd0 : m - r;
                end
            end
            FN_ADD:  r = (a + b >= m) ? a + b - m : a + b;
            FN_SUB:  r = (a >= b) ? a - b : a + m - b;
            FN_MUL:  r = mod_mul(a, b, m);
            FN_POW:  r = mod_pow(a, {1'b0, e}, m);
            FN_INV:  r = mod_inv(a, m);
            FN_DIV:  r = mod_mul(a, mod_inv(b, m), m);
            FN_INC:  r = (a + 64'd1) % m;
            FN_DEC:  r = (a + m - 64'd1) % m;
            FN_NEG:  r = (a == 64'd0) ? 64'd0 : m - a;
            FN_EQ:   r = (a == b) ? 64'd1 : 64'd0;
            FN_NEQ:  r = (a != b) ? 64'd1 : 64'd0;
            default: r = '0;
        endcase
        return r[VW-1:0];
    endfunction

    // result checker and watchdog
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("%0t watchdog expired", $time);
            $display("modular_arithmetic_unit verification failed");
            $finish;
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (result_q.size() == 0) begin
                err_cnt <= err_cnt + 1;
                $display("%0t unexpected result, actual %0d", $time, o_m_axis_tdata);
            end else begin
                if (o_m_axis_tdata !== {{(RES_W-VW){1'b0}}, result_q[0]}) begin
                    err_cnt <= err_cnt + 1;
                    $display("%0t result mismatch, expected %0d actual %0d",
                             $time, result_q[0], o_m_axis_tdata);
                end
                void'(result_q.pop_front());
            end
            rx_cnt <= rx_cnt + 1;
        end
    end

    // result receiver with random stalls and long hold-off
    always @(negedge i_clk) begin
        if (rx_cnt != rx_seen) begin
            rx_seen  = rx_cnt;
            rx_stall = quiet ? 0 : $urandom_range(0, 8);
        end
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rx_stall  = hold_len;
        end
        if (rx_stall > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // one request, predicted at acceptance
    task automatic send_request(logic [3:0] fn, logic [VW-1:0] a, logic [VW-1:0] b,
                                logic [EW-1:0] e, logic [63:0] raw);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= fn;
        i_s_axis_tdata  <= {{(DATA_W-2*VW-EW-RAW_W){1'b0}}, raw, e, b, a};
        do @(posedge i_clk); while (!o_s_axis_tready);
        result_q.push_back(residue_of(fn, a, b, e, raw));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic set_modulus(logic [VW-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        cur_modulus = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // operand mostly reduced, sometimes anywhere in the 31-bit range
    function automatic logic [VW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return VW'($urandom_range(0, 32'h7FFFFFFE));
            1: return cur_modulus - VW'(1);
            2: return VW'($urandom_range(0, 1));
            default: return VW'($urandom_range(0, cur_modulus - VW'(1)));
        endcase
    endfunction

    task automatic test_edge_cases();
        logic [VW-1:0] mx;
        mx = cur_modulus - VW'(1);
        send_request(FN_REDUCE, 0, 0, 0, 64'h7FFFFFFFFFFFFFFF);
        send_request(FN_REDUCE, 0, 0, 0, 64'h8000000000000000);
        send_request(FN_REDUCE, 0, 0, 0, 64'hFFFFFFFFFFFFFFFF);
        send_request(FN_REDUCE, 0, 0, 0, 64'd0);
        send_request(FN_REDUCE, 0, 0, 0, -64'sd998244353);
        send_request(FN_ADD, mx, mx, 0, 0);
        send_request(FN_SUB, 0, mx, 0, 0);
        send_request(FN_MUL, mx, mx, 0, 0);
        send_request(FN_POW, 0, 0, 0, 0);
        send_request(FN_POW, 12345, 0, 0, 0);
        send_request(FN_POW, mx, 0, {EW{1'b1}}, 0);
        send_request(FN_INV, 0, 0, 0, 0);
        send_request(FN_INV, 1, 0, 0, 0);
        send_request(FN_DIV, 77, 0, 0, 0);
        send_request(FN_DIV, mx, 3, 0, 0);
        send_request(FN_INC, mx, 0, 0, 0);
        send_request(FN_DEC, 0, 0, 0, 0);
        send_request(FN_NEG, 0, 0, 0, 0);
        send_request(FN_NEG, 5, 0, 0, 0);
        send_request(FN_EQ, 31'h7FFFFFFE, 31'h7FFFFFFE % cur_modulus, 0, 0);
        send_request(FN_NEQ, 4, 4, 0, 0);
        send_request(4'd12, 1, 1, 1, 1);
        send_request(4'd15, mx, mx, {EW{1'b1}}, '1);
    endtask

    task automatic test_random_ops(int count);
        logic [3:0]    fn;
        logic [EW-1:0] e;
        logic [63:0]   raw;
        for (int i = 0; i < count; i++) begin
            fn = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
            case ($urandom_range(0, 9))
                0:       e = EW'({$urandom, $urandom});
                1, 2:    e = EW'($urandom_range(0, 16'hFFFF));
                default: e = EW'($urandom_range(0, 40));
            endcase
            if ($urandom_range(0, 3) == 0) raw = 64'($signed($urandom_range(0, 2000)) - 1000);
            else raw = {$urandom, $urandom};
            send_request(fn, pick_operand(), pick_operand(), e, raw);
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_output_stall();
        wait_idle();
        hold_len = 400;
        hold_seq = hold_seq + 1;
        test_random_ops(6);
    endtask

    initial begin
        cur_modulus = MOD_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_random_ops(350);
        test_output_stall();
        set_modulus(31'd2);
        test_edge_cases();
        test_random_ops(150);
        set_modulus(MOD_MAX);
        test_edge_cases();
        test_random_ops(300);
        set_modulus(31'd7);
        test_random_ops(200);
        set_modulus(31'd1000000);
        test_random_ops(150);
        set_modulus(31'd13);
        quiet = 1'b1;
        test_random_ops(250);
        quiet = 1'b0;
        set_modulus(MOD_RESET);
        test_random_ops(150);

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && result_q.size() == 0)
            $display("modular_arithmetic_unit verification clean");
        else
            $display("modular_arithmetic_unit verification failed");
        $finish;
    end

endmodule
